// ===== hdl/ket_pkg.sv =====
// ----------------------------------------------------------------------------
// ket_pkg
// Shared sizes, operation and status codes, and the command and status
// structs that join the controller and the datapath of the keyed entry table.
// ----------------------------------------------------------------------------
package ket_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int NAME_BYTES  = 8;

    localparam int ADDR_W    = $clog2(MAX_ENTRIES);
    localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W     = 5;
    localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int KEY_W     = 32;
    localparam int PAYLOAD_W = 64;
    localparam int ENTRY_W   = PAYLOAD_W + KEY_W;
    localparam int ACTION_W  = 2;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;

    localparam int IN_TDATA_W  = 2 * KEY_W + PAYLOAD_W;
    localparam int IN_TUSER_W  = ACTION_W;
    localparam int OUT_TDATA_W = 72;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Only the low NAME_BYTES bytes of a payload are kept.
    localparam logic [PAYLOAD_W-1:0] NAME_MASK =
        {PAYLOAD_W{1'b1}} >> (PAYLOAD_W - 8 * NAME_BYTES);

    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_UPDATE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUP     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic load;
        logic scan;
        logic decide;
        logic shift;
        logic shrink;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic             scan_done;
        logic             need_shift;
        logic             shift_done;
        logic             out_free;
        logic [CNT_W-1:0] count;
    } t_stat;

endpackage

// ===== hdl/ket_ram.sv =====
// ----------------------------------------------------------------------------
// ket_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ket_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ket_datapath.sv =====
// ----------------------------------------------------------------------------
// ket_datapath
// Entry memory, key scan, delete compaction, capacity register, entry count
// and the output register of the keyed entry table.
// ----------------------------------------------------------------------------
module ket_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ket_pkg::t_cmd                   i_cmd,
    output ket_pkg::t_stat                  o_stat,
    input  logic                            i_cfg_we,
    input  logic [ket_pkg::CAP_W-1:0]       i_cfg_wdata,
    input  logic [ket_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic [ket_pkg::IN_TUSER_W-1:0]  i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [ket_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int AW = ket_pkg::ADDR_W;
    localparam int CW = ket_pkg::CNT_W;
    localparam int KW = ket_pkg::KEY_W;
    localparam int PW = ket_pkg::PAYLOAD_W;
    localparam int EW = ket_pkg::ENTRY_W;

    logic [ket_pkg::CAP_W-1:0]    r_cap;
    logic [CW-1:0]                r_count;

    logic [ket_pkg::ACTION_W-1:0] r_action;
    logic signed [KW-1:0]         r_key;
    logic signed [KW-1:0]         r_new_key;
    logic [PW-1:0]                r_payload;

    logic [CW-1:0]                r_scan_idx;
    logic                         r_scan_pend;
    logic [AW-1:0]                r_pend_idx;
    logic                         r_key_hit;
    logic                         r_nkey_hit;
    logic [AW-1:0]                r_hit_idx;
    logic [PW-1:0]                r_hit_payload;

    logic [CW-1:0]                r_sh_rd;
    logic                         r_sh_pend;
    logic [AW-1:0]                r_wr_ptr;

    logic [ket_pkg::STATUS_W-1:0] r_status;
    logic [PW-1:0]                r_found;

    logic                         r_out_valid;
    logic [ket_pkg::STATUS_W-1:0] r_out_status;
    logic [PW-1:0]                r_out_found;
    logic [ket_pkg::COUNT_W-1:0]  r_out_count;

    logic                         w_we;
    logic [AW-1:0]                w_waddr;
    logic [EW-1:0]                w_wdata;
    logic [AW-1:0]                w_raddr;
    logic [EW-1:0]                w_rdata;
    logic signed [KW-1:0]         w_rd_key;
    logic [PW-1:0]                w_rd_payload;

    logic                         w_scan_more;
    logic                         w_sh_more;
    logic                         w_full;
    logic                         w_add_ok;
    logic                         w_upd_ok;
    logic [ket_pkg::STATUS_W-1:0] w_status;
    logic [PW-1:0]                w_found;

    assign w_rd_key     = w_rdata[KW-1:0];
    assign w_rd_payload = w_rdata[EW-1:KW];
    assign w_scan_more  = r_scan_idx < r_count;
    assign w_sh_more    = r_sh_rd < r_count;

    // The capacity in effect is the smaller of the register and the table depth.
    assign w_full = (CMP_W_EXT(r_count) >= CMP_W_EXT_CAP(r_cap))
                 || (r_count >= CW'(ket_pkg::MAX_ENTRIES));

    function automatic logic [ket_pkg::CMP_W-1:0] CMP_W_EXT(input logic [CW-1:0] v);
        return ket_pkg::CMP_W'(v);
    endfunction

    function automatic logic [ket_pkg::CMP_W-1:0] CMP_W_EXT_CAP(
        input logic [ket_pkg::CAP_W-1:0] v
    );
        return ket_pkg::CMP_W'(v);
    endfunction

    always_comb begin
        w_status = ket_pkg::ST_OK;
        w_found  = '0;
        w_add_ok = 1'b0;
        w_upd_ok = 1'b0;
        unique case (r_action)
            ket_pkg::ACT_ADD: begin
                if (w_full) begin
                    w_status = ket_pkg::ST_FULL;
                end else if (r_key_hit) begin
                    w_status = ket_pkg::ST_DUP;
                end else begin
                    w_add_ok = 1'b1;
                end
            end
            ket_pkg::ACT_DELETE: begin
                if (!r_key_hit) begin
                    w_status = ket_pkg::ST_MISSING;
                end
            end
            ket_pkg::ACT_LOOKUP: begin
                if (!r_key_hit) begin
                    w_status = ket_pkg::ST_MISSING;
                end else begin
                    w_found = r_hit_payload;
                end
            end
            ket_pkg::ACT_UPDATE: begin
                // A clash with another entry's key wins over a missing key.
                if ((r_new_key != r_key) && r_nkey_hit) begin
                    w_status = ket_pkg::ST_DUP;
                end else if (!r_key_hit) begin
                    w_status = ket_pkg::ST_MISSING;
                end else begin
                    w_upd_ok = 1'b1;
                end
            end
            default: begin
                w_status = ket_pkg::ST_OK;
            end
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_wr_ptr;
        w_wdata = w_rdata;
        if (i_cmd.decide && w_add_ok) begin
            w_we    = 1'b1;
            w_waddr = r_count[AW-1:0];
            w_wdata = {r_payload, r_key};
        end else if (i_cmd.decide && w_upd_ok) begin
            w_we    = 1'b1;
            w_waddr = r_hit_idx;
            w_wdata = {r_payload, r_new_key};
        end else if (i_cmd.shift && r_sh_pend) begin
            w_we    = 1'b1;
            w_waddr = r_wr_ptr;
            w_wdata = w_rdata;
        end
    end

    assign w_raddr = i_cmd.shift ? r_sh_rd[AW-1:0] : r_scan_idx[AW-1:0];

    ket_ram #(
        .WIDTH (EW),
        .DEPTH (ket_pkg::MAX_ENTRIES)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= ket_pkg::CAP_RESET;
            r_count     <= '0;
            r_scan_pend <= 1'b0;
            r_sh_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.decide && w_add_ok) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.shrink) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.load) begin
                r_scan_pend <= 1'b0;
            end else if (i_cmd.scan) begin
                r_scan_pend <= w_scan_more;
            end
            if (i_cmd.decide) begin
                r_sh_pend <= 1'b0;
            end else if (i_cmd.shift) begin
                r_sh_pend <= w_sh_more;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action   <= i_s_tuser;
            r_key      <= i_s_tdata[KW-1:0];
            r_new_key  <= i_s_tdata[2*KW-1:KW];
            r_payload  <= i_s_tdata[2*KW+PW-1:2*KW] & ket_pkg::NAME_MASK;
            r_scan_idx <= '0;
            r_key_hit  <= 1'b0;
            r_nkey_hit <= 1'b0;
        end else if (i_cmd.scan) begin
            if (w_scan_more) begin
                r_scan_idx <= r_scan_idx + CW'(1);
            end
            r_pend_idx <= r_scan_idx[AW-1:0];
            // The read issued last cycle is compared now; the first match wins.
            if (r_scan_pend) begin
                if ((w_rd_key == r_key) && !r_key_hit) begin
                    r_key_hit     <= 1'b1;
                    r_hit_idx     <= r_pend_idx;
                    r_hit_payload <= w_rd_payload;
                end
                if (w_rd_key == r_new_key) begin
                    r_nkey_hit <= 1'b1;
                end
            end
        end

        if (i_cmd.decide) begin
            r_status <= w_status;
            r_found  <= w_found;
            r_sh_rd  <= CW'(r_hit_idx) + CW'(1);
            r_wr_ptr <= r_hit_idx;
        end else if (i_cmd.shift) begin
            // Each cycle reads the entry above and writes the one read before.
            if (w_sh_more) begin
                r_sh_rd <= r_sh_rd + CW'(1);
            end
            if (r_sh_pend) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
        end

        if (i_cmd.emit) begin
            r_out_status <= r_status;
            r_out_found  <= r_found;
            r_out_count  <= ket_pkg::COUNT_W'(r_count);
        end
    end

    assign o_stat.scan_done  = !w_scan_more && !r_scan_pend;
    assign o_stat.need_shift = (r_action == ket_pkg::ACT_DELETE) && r_key_hit;
    assign o_stat.shift_done = !w_sh_more && !r_sh_pend;
    assign o_stat.out_free   = !r_out_valid || i_m_tready;
    assign o_stat.count      = r_count;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_count, r_out_found, r_out_status};

endmodule

// ===== hdl/ket_ctrl.sv =====
// ----------------------------------------------------------------------------
// ket_ctrl
// Sequencer of the keyed entry table: accept, scan, decide, compact, deliver.
// ----------------------------------------------------------------------------
module ket_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  ket_pkg::t_stat i_stat,
    output ket_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = i_stat.need_shift ? S_SHIFT : S_DONE;
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_stat.shift_done) begin
                    o_cmd.shrink = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                // Wait here only while the previous result is still unread.
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/keyed_entry_table.sv =====
// ----------------------------------------------------------------------------
// keyed_entry_table
// Packed table of keyed entries with add, delete (with compaction), lookup
// and update, one result per operation.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            contents
//  s         in         i_s_tvalid/o_s_tready tdata: key, new_key, payload
//                                            tuser: action
//  m         out        o_m_tvalid/i_m_tready tdata: status, found_payload,
//                                            entry_count
//  cfg       in         i_cfg_we             capacity_in_use
//
//  An operation scans the N entries of the table, N being the entry count:
//  the scan reads one entry a cycle and compares each key once its
//  registered read returns. A delete that finds its key then moves the M
//  entries above the deleted one down one place, one a cycle.
//  A new item is taken once the previous result sits in the output register.
//  Reset is synchronous and active low; it clears the count and the capacity
//  returns to 16. A stalled output holds the sequencer before its next result.
// ----------------------------------------------------------------------------
module keyed_entry_table (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ket_pkg::CAP_W-1:0]       i_cfg_wdata,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // key [31:0], new_key [63:32], payload [127:64]
    input  logic [ket_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // action [1:0]
    input  logic [ket_pkg::IN_TUSER_W-1:0]  i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // status [1:0], found_payload [65:2], entry_count [70:66], zero [71]
    output logic [ket_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    ket_pkg::t_cmd  w_cmd;
    ket_pkg::t_stat w_stat;

    ket_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ket_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // The table never holds more entries than its depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.count <= ket_pkg::CNT_W'(ket_pkg::MAX_ENTRIES))
        else $error("entry count beyond table depth");

    // After a transfer the block is busy with that item.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted again during an operation");

    // The count only moves while an operation is in progress.
    a_count_moves_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(w_stat.count) |-> !$past(o_s_tready))
        else $error("entry count changed while idle");

    // A result is only loaded when the output register is free.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_stat.out_free)
        else $error("result overwrote an unread result");

endmodule

// ===== tb/sv/tb_keyed_entry_table.sv =====
// ----------------------------------------------------------------------------
// tb_keyed_entry_table
// Self-checking testbench for the keyed entry table. A short table of directed
// operations is followed by random phases at several capacities. Every result
// transfer is compared field by field with the oldest expected reply.
// ----------------------------------------------------------------------------
module tb_keyed_entry_table;

    localparam int POOL_SIZE   = 20;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 70;
    localparam int SETTLE      = 4 + 2 * ket_pkg::MAX_ENTRIES + 8;

    typedef struct {
        logic [ket_pkg::ACTION_W-1:0]  action;
        logic [ket_pkg::KEY_W-1:0]     key;
        logic [ket_pkg::KEY_W-1:0]     new_key;
        logic [ket_pkg::PAYLOAD_W-1:0] payload;
    } t_table_op;

    typedef struct {
        logic [ket_pkg::STATUS_W-1:0]  status;
        logic [ket_pkg::PAYLOAD_W-1:0] found;
        logic [ket_pkg::COUNT_W-1:0]   count;
    } t_table_reply;

    typedef struct {
        t_table_op    op;
        bit           typed;
        t_table_reply reply;
    } t_directed_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [ket_pkg::CAP_W-1:0]       i_cfg_wdata;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    // key [31:0], new_key [63:32], payload [127:64]
    logic [ket_pkg::IN_TDATA_W-1:0]  i_s_tdata;
    // action [1:0]
    logic [ket_pkg::IN_TUSER_W-1:0]  i_s_tuser;
    logic                            o_m_tvalid;
    logic                            i_m_tready;
    // status [1:0], found_payload [65:2], entry_count [70:66], zero [71]
    logic [ket_pkg::OUT_TDATA_W-1:0] o_m_tdata;

    keyed_entry_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // Predicted table contents.
    logic [ket_pkg::KEY_W-1:0]     tbl_keys [ket_pkg::MAX_ENTRIES];
    logic [ket_pkg::PAYLOAD_W-1:0] tbl_payloads [ket_pkg::MAX_ENTRIES];
    int                            entry_total;
    int                            capacity_reg;

    t_table_reply  pending_replies [$];
    t_directed_row directed_rows [$];
    logic [ket_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

    int  mismatch_count;
    int  replies_seen;
    bit  idle_on;
    int  hold_cycles;
    int  add_pct;

    always #4 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 80) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int find_entry(logic [ket_pkg::KEY_W-1:0] k);
        for (int i = 0; i < entry_total; i++)
            if (tbl_keys[i] == k) return i;
        return -1;
    endfunction

    function automatic t_table_reply apply_table_op(t_table_op op);
        t_table_reply rep;
        int idx;
        int cap_eff;
        rep.status = ket_pkg::ST_OK;
        rep.found  = '0;
        cap_eff    = (capacity_reg < ket_pkg::MAX_ENTRIES) ? capacity_reg
                                                           : ket_pkg::MAX_ENTRIES;
        idx        = find_entry(op.key);
        case (op.action)
            ket_pkg::ACT_ADD: begin
                if (entry_total >= cap_eff) begin
                    rep.status = ket_pkg::ST_FULL;
                end else if (idx >= 0) begin
                    rep.status = ket_pkg::ST_DUP;
                end else begin
                    tbl_keys[entry_total]     = op.key;
                    tbl_payloads[entry_total] = op.payload & ket_pkg::NAME_MASK;
                    entry_total++;
                end
            end
            ket_pkg::ACT_DELETE: begin
                if (idx < 0) begin
                    rep.status = ket_pkg::ST_MISSING;
                end else begin
                    for (int j = idx; j + 1 < entry_total; j++) begin
                        tbl_keys[j]     = tbl_keys[j + 1];
                        tbl_payloads[j] = tbl_payloads[j + 1];
                    end
                    entry_total--;
                end
            end
            ket_pkg::ACT_LOOKUP: begin
                if (idx < 0) rep.status = ket_pkg::ST_MISSING;
                else rep.found = tbl_payloads[idx];
            end
            default: begin
                // A new key held elsewhere wins over a missing old key.
                if (op.new_key != op.key && find_entry(op.new_key) >= 0) begin
                    rep.status = ket_pkg::ST_DUP;
                end else if (idx < 0) begin
                    rep.status = ket_pkg::ST_MISSING;
                end else begin
                    tbl_keys[idx]     = op.new_key;
                    tbl_payloads[idx] = op.payload & ket_pkg::NAME_MASK;
                end
            end
        endcase
        rep.count = ket_pkg::COUNT_W'(entry_total);
        return rep;
    endfunction

    function automatic void add_row(logic [ket_pkg::ACTION_W-1:0] action,
                                    logic [ket_pkg::KEY_W-1:0] key,
                                    logic [ket_pkg::KEY_W-1:0] new_key,
                                    logic [ket_pkg::PAYLOAD_W-1:0] payload, bit typed,
                                    logic [ket_pkg::STATUS_W-1:0] status,
                                    logic [ket_pkg::PAYLOAD_W-1:0] found, int count);
        t_directed_row row;
        row.op.action    = action;
        row.op.key       = key;
        row.op.new_key   = new_key;
        row.op.payload   = payload;
        row.typed        = typed;
        row.reply.status = status;
        row.reply.found  = found;
        row.reply.count  = ket_pkg::COUNT_W'(count);
        directed_rows.push_back(row);
    endfunction

    function automatic logic [ket_pkg::KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic t_table_op random_op();
        t_table_op op;
        int r;
        r = $urandom_range(0, 99);
        if (r < add_pct) op.action = ket_pkg::ACT_ADD;
        else if (r < add_pct + (100 - add_pct) * 2 / 5) op.action = ket_pkg::ACT_DELETE;
        else if (r < add_pct + (100 - add_pct) * 7 / 10) op.action = ket_pkg::ACT_LOOKUP;
        else op.action = ket_pkg::ACT_UPDATE;
        op.key     = pick_key();
        op.payload = {$urandom, $urandom};
        if (op.action == ket_pkg::ACT_UPDATE) begin
            r = $urandom_range(0, 99);
            if (r < 35) op.new_key = op.key;
            else op.new_key = pick_key();
        end else begin
            op.new_key = $urandom;
        end
        return op;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Offers one item and waits for its transfer; the expectation is queued
    // at the accepting edge. A typed expectation replaces the predicted one.
    task automatic offer_op(input t_table_op op, input bit typed,
                            input t_table_reply typed_reply);
        int gap;
        t_table_reply rep;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {op.payload, op.new_key, op.key};
        i_s_tuser  <= op.action;
        do @(posedge i_clk); while (!o_s_tready);
        rep = apply_table_op(op);
        pending_replies.push_back(typed ? typed_reply : rep);
    endtask

    task automatic write_capacity(input int value);
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= ket_pkg::CAP_W'(value);
        @(negedge i_clk);
        i_cfg_we     <= 1'b0;
        capacity_reg = value;
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_table_reply want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            replies_seen++;
            if (pending_replies.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          replies_seen));
            end else begin
                want = pending_replies.pop_front();
                if (o_m_tdata[1:0] !== want.status)
                    report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                              replies_seen, o_m_tdata[1:0], want.status));
                if (o_m_tdata[65:2] !== want.found)
                    report_mismatch($sformatf("result %0d payload %h, expected %h",
                                              replies_seen, o_m_tdata[65:2], want.found));
                if (o_m_tdata[70:66] !== want.count)
                    report_mismatch($sformatf("result %0d count %0d, expected %0d",
                                              replies_seen, o_m_tdata[70:66], want.count));
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial begin
        int stall_left;
        stall_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_m_tready  <= 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else if (!idle_on || $urandom_range(0, 3) != 0) begin
                i_m_tready <= 1'b1;
            end else begin
                stall_left = pick_gap();
                if (stall_left == 0) begin
                    i_m_tready <= 1'b1;
                end else begin
                    i_m_tready <= 1'b0;
                    stall_left--;
                end
            end
        end
    end

    initial begin
        #3_200_000;
        $display("** keyed_entry_table: FAILED **");
        $finish;
    end

    initial begin
        int cap_plan [PHASES];
        int add_plan [PHASES];
        int drain_cycles;
        t_table_op    op;
        t_table_reply none;
        logic [ket_pkg::PAYLOAD_W-1:0] ones;

        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = '0;
        i_m_tready     = 1'b0;
        mismatch_count = 0;
        replies_seen   = 0;
        idle_on        = 1'b1;
        hold_cycles    = 0;
        add_pct        = 45;
        entry_total    = 0;
        capacity_reg   = int'(ket_pkg::CAP_RESET);
        none           = '{default: '0};
        ones           = '1;

        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'hFFFF_FFFF;
        key_pool[3] = 32'h0000_0000;
        for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

        cap_plan = '{2, 0, 31, 1, 16, 0, 5};
        cap_plan[5] = $urandom_range(3, 15);
        add_plan = '{50, 30, 75, 20, 50, 55, 50};

        // Empty table, extreme keys and payloads, duplicates, both update
        // refusals, a payload-only update, and deletes at either end.
        add_row(ket_pkg::ACT_LOOKUP, 32'd0, 32'd0, 64'd0, 1, ket_pkg::ST_MISSING, 64'd0, 0);
        add_row(ket_pkg::ACT_DELETE, 32'd5, 32'd0, 64'd0, 1, ket_pkg::ST_MISSING, 64'd0, 0);
        add_row(ket_pkg::ACT_UPDATE, 32'd1, 32'd2, ones, 1, ket_pkg::ST_MISSING, 64'd0, 0);
        add_row(ket_pkg::ACT_ADD, 32'h8000_0000, 32'hFFFF_FFFF, ones, 1,
                ket_pkg::ST_OK, 64'd0, 1);
        add_row(ket_pkg::ACT_ADD, 32'h7FFF_FFFF, 32'd0, 64'd0, 1, ket_pkg::ST_OK, 64'd0, 2);
        add_row(ket_pkg::ACT_ADD, 32'd0, 32'd0, 64'h0123_4567_89AB_CDEF, 1,
                ket_pkg::ST_OK, 64'd0, 3);
        add_row(ket_pkg::ACT_ADD, 32'h8000_0000, 32'd0, 64'd7, 1, ket_pkg::ST_DUP, 64'd0, 3);
        add_row(ket_pkg::ACT_LOOKUP, 32'h8000_0000, 32'd0, 64'd0, 1, ket_pkg::ST_OK, ones, 3);
        add_row(ket_pkg::ACT_LOOKUP, 32'h7FFF_FFFF, 32'd0, ones, 1, ket_pkg::ST_OK, 64'd0, 3);
        add_row(ket_pkg::ACT_UPDATE, 32'd0, 32'h7FFF_FFFF, 64'd1, 1,
                ket_pkg::ST_DUP, 64'd0, 3);
        add_row(ket_pkg::ACT_UPDATE, 32'd99, 32'd0, 64'd1, 1, ket_pkg::ST_DUP, 64'd0, 3);
        add_row(ket_pkg::ACT_UPDATE, 32'd99, 32'd100, 64'd1, 1,
                ket_pkg::ST_MISSING, 64'd0, 3);
        add_row(ket_pkg::ACT_UPDATE, 32'd0, 32'd0, 64'hAAAA_AAAA_AAAA_AAAA, 1,
                ket_pkg::ST_OK, 64'd0, 3);
        add_row(ket_pkg::ACT_LOOKUP, 32'd0, 32'd0, 64'd0, 0, ket_pkg::ST_OK, 64'd0, 0);
        add_row(ket_pkg::ACT_UPDATE, 32'd0, 32'd42, 64'h5555_5555_5555_5555, 1,
                ket_pkg::ST_OK, 64'd0, 3);
        add_row(ket_pkg::ACT_DELETE, 32'h8000_0000, 32'd0, 64'd0, 1, ket_pkg::ST_OK, 64'd0, 2);
        add_row(ket_pkg::ACT_LOOKUP, 32'h7FFF_FFFF, 32'd0, 64'd0, 0, ket_pkg::ST_OK, 64'd0, 0);
        add_row(ket_pkg::ACT_LOOKUP, 32'd42, 32'd0, 64'd0, 0, ket_pkg::ST_OK, 64'd0, 0);
        add_row(ket_pkg::ACT_DELETE, 32'd42, 32'd0, 64'd0, 1, ket_pkg::ST_OK, 64'd0, 1);
        add_row(ket_pkg::ACT_DELETE, 32'd42, 32'd0, 64'd0, 1, ket_pkg::ST_MISSING, 64'd0, 1);
        add_row(ket_pkg::ACT_ADD, 32'hFFFF_FFFF, 32'd0, 64'h8000_0000_0000_0001, 1,
                ket_pkg::ST_OK, 64'd0, 2);
        add_row(ket_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 32'd0, 64'd0, 0, ket_pkg::ST_OK, 64'd0, 0);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            offer_op(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].reply);
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            write_capacity(cap_plan[p]);
            idle_on = (p != 4);
            add_pct = add_plan[p];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // The long hold-off lets the block back up while items queue.
                if (p == 2 && n == 5) hold_cycles = 400;
                op = random_op();
                offer_op(op, 1'b0, none);
            end
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end

        drain_cycles = 0;
        while (pending_replies.size() != 0 && drain_cycles < 5000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (SETTLE) @(posedge i_clk);
        if (pending_replies.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_replies.size()));

        if (mismatch_count == 0) begin
            $display("** keyed_entry_table: PASSED **");
        end else begin
            $display("** keyed_entry_table: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ket_pkg.sv
hdl/ket_ram.sv
hdl/ket_datapath.sv
hdl/ket_ctrl.sv
hdl/keyed_entry_table.sv
tb/sv/tb_keyed_entry_table.sv
